// ===== rtl/vgu_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vgu_pkg
// Shared types and constants of the 3D vector geometry unit.
// ---------------------------------------------------------------------------
package vgu_pkg;

    // Operation codes
    typedef enum logic [2:0] {
        FN_ADD  = 3'd0,
        FN_SUB  = 3'd1,
        FN_NORM = 3'd2,
        FN_DIST = 3'd3,
        FN_ZERO = 3'd4
    } t_func;

    localparam int unsigned COMP_W     = 32;            // Q15.16 component
    localparam int unsigned SUM_W      = 64;            // sum of squares
    localparam int unsigned ROOT_W     = 32;            // floor square root
    localparam int unsigned REM_W      = 34;            // root remainder
    localparam int unsigned MAG_W      = ROOT_W + 1;    // rounded magnitude
    localparam int unsigned DIST_W     = 31;
    localparam int unsigned SQRT_STEPS = ROOT_W;        // one root bit per stage
    localparam int unsigned QUO_BITS   = 17;            // normalised |q| <= 2^16
    localparam int unsigned DVD_W      = 48;            // |a| << 16 plus half m
    localparam int unsigned CMP_W      = MAG_W + QUO_BITS - 1;

    localparam logic [COMP_W-1:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [COMP_W-1:0] S32_MIN = 32'h8000_0000;
    localparam logic [DIST_W-1:0] DIST_MAX = 31'h7FFF_FFFF;

    // Sideband that travels with every item through the pipeline
    typedef struct packed {
        logic [2:0]             func;
        logic [2:0][COMP_W-1:0] vec;    // add/sub result, |a| or distance
        logic [2:0]             neg;    // sign of each A component
        logic                   big;    // a difference of 2^31 or more
        logic                   zero;   // A is the zero vector
    } t_side;

    // Result item fields
    typedef struct packed {
        logic [2:0][COMP_W-1:0] res;
        logic [DIST_W-1:0]      dist_val;
        logic                   zflag;
        logic                   err;
    } t_res;

endpackage

// ===== rtl/vgu_in_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vgu_in_if
// Input channel: operation code and vectors A and B.
// ---------------------------------------------------------------------------
`default_nettype none
interface vgu_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         func;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;

    modport source (output valid, func, a_x, a_y, a_z, b_x, b_y, b_z, input ready);
    modport sink   (input valid, func, a_x, a_y, a_z, b_x, b_y, b_z, output ready);
endinterface
`default_nettype wire

// ===== rtl/vgu_out_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vgu_out_if
// Output channel: result vector, distance and flags.
// ---------------------------------------------------------------------------
`default_nettype none
interface vgu_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] res_x;
    logic signed [31:0] res_y;
    logic signed [31:0] res_z;
    logic [30:0]        distance;
    logic               zero_flag;
    logic               error;

    modport source (output valid, res_x, res_y, res_z, distance, zero_flag, error,
                    input ready);
    modport sink   (input valid, res_x, res_y, res_z, distance, zero_flag, error,
                    output ready);
endinterface
`default_nettype wire

// ===== rtl/vgu_sqsum.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vgu_sqsum
// Front end: add/sub with saturation, operand select, squares, sum of squares.
// Three register stages.
// ---------------------------------------------------------------------------
`default_nettype none
module vgu_sqsum
    import vgu_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic                   i_valid,
    input  wire logic [2:0]             i_func,
    input  wire logic [2:0][COMP_W-1:0] i_a,
    input  wire logic [2:0][COMP_W-1:0] i_b,
    output logic                        o_valid,
    output t_side                       o_side,
    output logic [SUM_W-1:0]            o_sum
);

    logic [2:0][COMP_W-1:0] w_op;
    logic [2:0][COMP_W-1:0] w_vec;
    logic [2:0]             w_big;
    logic [2:0]             w_nz;
    t_side                  w_side;

    // Per-component front arithmetic
    for (genvar l = 0; l < 3; l++) begin : g_lane
        logic [COMP_W:0]   w_sum;
        logic [COMP_W:0]   w_dif;
        logic [COMP_W:0]   w_dif_abs;
        logic [COMP_W-1:0] w_sat_sum;
        logic [COMP_W-1:0] w_sat_dif;
        logic [COMP_W-1:0] w_abs_a;

        assign w_sum = {i_a[l][COMP_W-1], i_a[l]} + {i_b[l][COMP_W-1], i_b[l]};
        assign w_dif = {i_a[l][COMP_W-1], i_a[l]} - {i_b[l][COMP_W-1], i_b[l]};

        // overflow when the two top bits disagree
        assign w_sat_sum = (w_sum[COMP_W] != w_sum[COMP_W-1])
                         ? (w_sum[COMP_W] ? S32_MIN : S32_MAX) : w_sum[COMP_W-1:0];
        assign w_sat_dif = (w_dif[COMP_W] != w_dif[COMP_W-1])
                         ? (w_dif[COMP_W] ? S32_MIN : S32_MAX) : w_dif[COMP_W-1:0];

        assign w_abs_a   = i_a[l][COMP_W-1] ? (COMP_W'(0) - i_a[l]) : i_a[l];
        assign w_dif_abs = w_dif[COMP_W] ? ((COMP_W+1)'(0) - w_dif) : w_dif;
        assign w_big[l]  = (w_dif_abs[COMP_W:COMP_W-1] != 2'b00);
        assign w_nz[l]   = (i_a[l] != '0);

        assign w_op[l] = (i_func == FN_NORM) ? w_abs_a
                       : (w_big[l] ? '0 : w_dif_abs[COMP_W-1:0]);

        always_comb begin
            unique case (i_func)
                FN_ADD:  w_vec[l] = w_sat_sum;
                FN_SUB:  w_vec[l] = w_sat_dif;
                FN_NORM: w_vec[l] = w_abs_a;
                default: w_vec[l] = '0;
            endcase
        end
    end

    always_comb begin
        w_side.func = i_func;
        w_side.vec  = w_vec;
        w_side.neg  = {i_a[2][COMP_W-1], i_a[1][COMP_W-1], i_a[0][COMP_W-1]};
        w_side.big  = |w_big;
        w_side.zero = ~|w_nz;
    end

    // Stage 1: operands
    logic                   r1_valid;
    t_side                  r1_side;
    logic [2:0][COMP_W-1:0] r1_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_side <= w_side;
            r1_op   <= w_op;
        end
    end

    // Stage 2: squares, one 32x32 multiplier per lane
    logic                  r2_valid;
    t_side                 r2_side;
    logic [2:0][SUM_W-1:0] r2_sq;
    logic [2:0][SUM_W-1:0] w_sq;

    for (genvar l = 0; l < 3; l++) begin : g_sq
        assign w_sq[l] = SUM_W'(r1_op[l]) * SUM_W'(r1_op[l]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_side <= r1_side;
            r2_sq   <= w_sq;
        end
    end

    // Stage 3: sum of squares, at most 3 * 2^62
    logic             r3_valid;
    t_side            r3_side;
    logic [SUM_W-1:0] r3_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_side <= r2_side;
            r3_sum  <= r2_sq[0] + r2_sq[1] + r2_sq[2];
        end
    end

    assign o_valid = r3_valid;
    assign o_side  = r3_side;
    assign o_sum   = r3_sum;

endmodule
`default_nettype wire

// ===== rtl/vgu_sqrt.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vgu_sqrt
// Pipelined square root, one root bit per stage, then round to nearest.
// ---------------------------------------------------------------------------
`default_nettype none
module vgu_sqrt
    import vgu_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire t_side            i_side,
    input  wire logic [SUM_W-1:0] i_sum,
    output logic                  o_valid,
    output t_side                 o_side,
    output logic [MAG_W-1:0]      o_mag
);

    logic              r_v    [SQRT_STEPS];
    t_side             r_side [SQRT_STEPS];
    logic [SUM_W-1:0]  r_rad  [SQRT_STEPS-1];
    logic [REM_W-1:0]  r_rem  [SQRT_STEPS];
    logic [ROOT_W-1:0] r_root [SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        logic              w_v;
        t_side             w_side;
        logic [SUM_W-1:0]  w_rad;
        logic [REM_W-1:0]  w_rem;
        logic [ROOT_W-1:0] w_root;
        logic [REM_W+1:0]  w_rin;
        logic [REM_W+1:0]  w_trial;
        logic [REM_W+1:0]  w_diff;
        logic              w_take;

        if (k == 0) begin : g_first
            assign w_v    = i_valid;
            assign w_side = i_side;
            assign w_rad  = i_sum;
            assign w_rem  = '0;
            assign w_root = '0;
        end else begin : g_next
            assign w_v    = r_v[k-1];
            assign w_side = r_side[k-1];
            assign w_rad  = r_rad[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
        end

        // bring down the next two radicand bits, try (root*4 + 1)
        assign w_rin   = {w_rem, w_rad[SUM_W-1:SUM_W-2]};
        assign w_trial = (REM_W+2)'({w_root, 2'b01});
        assign w_diff  = w_rin - w_trial;
        assign w_take  = (w_rin >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= w_side;
                if (w_take) begin
                    r_rem[k]  <= w_diff[REM_W-1:0];
                    r_root[k] <= {w_root[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= w_rin[REM_W-1:0];
                    r_root[k] <= {w_root[ROOT_W-2:0], 1'b0};
                end
            end
        end

        if (k < SQRT_STEPS - 1) begin : g_rad
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rad[k] <= {w_rad[SUM_W-3:0], 2'b00};
                end
            end
        end
    end

    // Round: remainder S - r*r above r means the upper neighbour is nearer
    logic             r_rv;
    t_side            r_rside;
    logic [MAG_W-1:0] r_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv <= 1'b0;
        end else if (i_en) begin
            r_rv <= r_v[SQRT_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rside <= r_side[SQRT_STEPS-1];
            r_mag   <= MAG_W'(r_root[SQRT_STEPS-1])
                     + MAG_W'(r_rem[SQRT_STEPS-1] > REM_W'(r_root[SQRT_STEPS-1]));
        end
    end

    assign o_valid = r_rv;
    assign o_side  = r_rside;
    assign o_mag   = r_mag;

endmodule
`default_nettype wire

// ===== rtl/vgu_div.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vgu_div
// Pipelined restoring divider, three lanes, one quotient bit per stage.
// Computes (|a| * 2^16 + floor(m/2)) / m for each component.
// ---------------------------------------------------------------------------
`default_nettype none
module vgu_div
    import vgu_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire logic                    i_valid,
    input  wire t_side                   i_side,
    input  wire logic [MAG_W-1:0]        i_mag,
    output logic                         o_valid,
    output t_side                        o_side,
    output logic [2:0][QUO_BITS-1:0]     o_quo
);

    // Prepare stage: dividends
    logic                  r_pv;
    t_side                 r_pside;
    logic [MAG_W-1:0]      r_pmag;
    logic [2:0][DVD_W-1:0] r_pdvd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (i_en) begin
            r_pv <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pside <= i_side;
            r_pmag  <= i_mag;
            for (int l = 0; l < 3; l++) begin
                r_pdvd[l] <= {i_side.vec[l], 16'h0000} + DVD_W'(i_mag[MAG_W-1:1]);
            end
        end
    end

    logic                     r_v    [QUO_BITS];
    t_side                    r_side [QUO_BITS];
    logic [2:0][QUO_BITS-1:0] r_q    [QUO_BITS];
    logic [2:0][DVD_W-1:0]    r_rem  [QUO_BITS-1];
    logic [MAG_W-1:0]         r_dvs  [QUO_BITS-1];

    for (genvar k = 0; k < QUO_BITS; k++) begin : g_step
        logic                     w_v;
        t_side                    w_side;
        logic [2:0][QUO_BITS-1:0] w_q;
        logic [2:0][DVD_W-1:0]    w_rem;
        logic [MAG_W-1:0]         w_dvs;
        logic [CMP_W-1:0]         w_sh;
        logic [2:0]               w_take;
        logic [2:0][QUO_BITS-1:0] w_qn;
        logic [2:0][DVD_W-1:0]    w_remn;

        if (k == 0) begin : g_first
            assign w_v    = r_pv;
            assign w_side = r_pside;
            assign w_q    = '0;
            assign w_rem  = r_pdvd;
            assign w_dvs  = r_pmag;
        end else begin : g_next
            assign w_v    = r_v[k-1];
            assign w_side = r_side[k-1];
            assign w_q    = r_q[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_dvs  = r_dvs[k-1];
        end

        // divisor aligned to quotient bit QUO_BITS-1-k
        assign w_sh = CMP_W'(w_dvs) << (QUO_BITS - 1 - k);

        for (genvar l = 0; l < 3; l++) begin : g_lane
            logic [CMP_W-1:0] w_r;
            assign w_r       = CMP_W'(w_rem[l]);
            assign w_take[l] = (w_r >= w_sh);
            assign w_remn[l] = w_take[l] ? DVD_W'(w_r - w_sh) : w_rem[l];
            assign w_qn[l]   = w_q[l] | (QUO_BITS'(w_take[l]) << (QUO_BITS - 1 - k));
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= w_side;
                r_q[k]    <= w_qn;
            end
        end

        if (k < QUO_BITS - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= w_remn;
                    r_dvs[k] <= w_dvs;
                end
            end
        end
    end

    assign o_valid = r_v[QUO_BITS-1];
    assign o_side  = r_side[QUO_BITS-1];
    assign o_quo   = r_q[QUO_BITS-1];

endmodule
`default_nettype wire

// ===== rtl/vector3_geometry_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vector3_geometry_unit
// 3D vector unit in signed Q15.16: add, subtract, normalise, distance, zero.
// ---------------------------------------------------------------------------
// Usage:
//   i_in carries one item per handshake: func, vectors A and B. o_out returns
//   exactly one result item per input item, in order.
//   From acceptance to o_out.valid an item passes 3 front stages
//   (operands, squares, sum), 32 square-root stages (one root bit each),
//   1 rounding stage, 1 divider set-up stage, 17 divider stages (one
//   quotient bit each) and 1 output stage. Every operation takes the same
//   path, so results never overtake each other.
//   Throughput is one item per cycle while the skid register is empty; each
//   stage holds one item. A skid register behind the output stage catches
//   an item the receiver did not take; while it is full the whole pipeline
//   holds and i_in.ready is low, so i_in.ready never depends on o_out.ready
//   in the same cycle. Reset (synchronous, active low) clears all valid
//   bits, the skid register's included; nothing is in flight afterwards.
// ---------------------------------------------------------------------------
`default_nettype none
module vector3_geometry_unit
    import vgu_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    vgu_in_if.sink    i_in,
    vgu_out_if.source o_out
);

    logic                     w_en;
    logic                     w_sq_v;
    t_side                    w_sq_side;
    logic [SUM_W-1:0]         w_sq_sum;
    logic                     w_rt_v;
    t_side                    w_rt_side;
    t_side                    w_dv_in_side;
    logic [MAG_W-1:0]         w_rt_mag;
    logic                     w_dv_v;
    t_side                    w_dv_side;
    logic [2:0][QUO_BITS-1:0] w_dv_q;
    t_res                     w_res;

    logic r_skid_v;
    logic n_skid_v;
    t_res r_skid;
    logic r_ov;
    t_res r_o;
    t_res w_show;

    // Pipeline advances whenever the skid register is empty
    assign w_en       = !r_skid_v;
    assign i_in.ready = w_en;

    vgu_sqsum u_sqsum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in.valid),
        .i_func  (i_in.func),
        .i_a     ({i_in.a_z, i_in.a_y, i_in.a_x}),
        .i_b     ({i_in.b_z, i_in.b_y, i_in.b_x}),
        .o_valid (w_sq_v),
        .o_side  (w_sq_side),
        .o_sum   (w_sq_sum)
    );

    vgu_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sq_v),
        .i_side  (w_sq_side),
        .i_sum   (w_sq_sum),
        .o_valid (w_rt_v),
        .o_side  (w_rt_side),
        .o_mag   (w_rt_mag)
    );

    // Distance is final after rounding; it rides in lane 0 of the sideband
    always_comb begin
        w_dv_in_side = w_rt_side;
        if (w_rt_side.func == FN_DIST) begin
            if (w_rt_side.big || (w_rt_mag > MAG_W'(DIST_MAX))) begin
                w_dv_in_side.vec[0] = COMP_W'(DIST_MAX);
            end else begin
                w_dv_in_side.vec[0] = COMP_W'(w_rt_mag[DIST_W-1:0]);
            end
        end
    end

    vgu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_rt_v),
        .i_side  (w_dv_in_side),
        .i_mag   (w_rt_mag),
        .o_valid (w_dv_v),
        .o_side  (w_dv_side),
        .o_quo   (w_dv_q)
    );

    // Result assembly
    always_comb begin
        w_res = '0;
        unique case (w_dv_side.func)
            FN_ADD, FN_SUB: begin
                w_res.res = w_dv_side.vec;
            end
            FN_NORM: begin
                if (w_dv_side.zero) begin
                    w_res.err = 1'b1;
                end else begin
                    for (int l = 0; l < 3; l++) begin
                        w_res.res[l] = w_dv_side.neg[l]
                                     ? (COMP_W'(0) - COMP_W'(w_dv_q[l]))
                                     : COMP_W'(w_dv_q[l]);
                    end
                end
            end
            FN_DIST: begin
                w_res.dist_val = w_dv_side.vec[0][DIST_W-1:0];
            end
            FN_ZERO: begin
                w_res.zflag = w_dv_side.zero;
            end
            default: begin
                w_res = '0;
            end
        endcase
    end

    // Output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= w_dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o <= w_res;
        end
    end

    // Skid register: takes the output item when it is not taken
    always_comb begin
        n_skid_v = r_skid_v;
        if (r_skid_v && o_out.ready) begin
            n_skid_v = 1'b0;
        end else if (!r_skid_v && r_ov && !o_out.ready) begin
            n_skid_v = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
        end else begin
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_v) begin
            r_skid <= r_o;
        end
    end

    assign w_show          = r_skid_v ? r_skid : r_o;
    assign o_out.valid     = r_skid_v || r_ov;
    assign o_out.res_x     = w_show.res[0];
    assign o_out.res_y     = w_show.res[1];
    assign o_out.res_z     = w_show.res[2];
    assign o_out.distance  = w_show.dist_val;
    assign o_out.zero_flag = w_show.zflag;
    assign o_out.error     = w_show.err;

endmodule
`default_nettype wire

// ===== rtl/vgu_chk.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vgu_chk
// Port-level checks on the vector geometry unit, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
module vgu_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] i_res_x,
    input wire logic [31:0] i_res_y,
    input wire logic [31:0] i_res_z,
    input wire logic [30:0] i_distance,
    input wire logic        i_zero_flag,
    input wire logic        i_error
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_res_x)
            && $stable(i_res_y) && $stable(i_res_z) && $stable(i_distance))
        else $error("result item changed while stalled");

    // input back-pressure only while a result item waits
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with no result pending");

    // an error item carries nothing else
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_error |-> i_res_x == 32'd0 && i_res_y == 32'd0
            && i_res_z == 32'd0 && i_distance == 31'd0 && !i_zero_flag)
        else $error("error item with non-zero fields");

    // scalar results leave the vector zero
    a_scalar_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_zero_flag || i_distance != 31'd0) |->
            i_res_x == 32'd0 && i_res_y == 32'd0 && i_res_z == 32'd0 && !i_error)
        else $error("scalar item with non-zero vector");

endmodule

bind vector3_geometry_unit vgu_chk u_vgu_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_res_x     (o_out.res_x),
    .i_res_y     (o_out.res_y),
    .i_res_z     (o_out.res_z),
    .i_distance  (o_out.distance),
    .i_zero_flag (o_out.zero_flag),
    .i_error     (o_out.error)
);
`default_nettype wire
